// File: rtl/saq_pkg.sv
package saq_pkg;

    localparam int ISQ_STEPS = 32;
    localparam int ISQ_TOP   = 2 * ISQ_STEPS - 2;
    localparam int DIV_STEPS = 15;
    localparam int QV_W      = 35;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam logic [1:0] PATH_GENERAL   = 2'd0;
    localparam logic [1:0] PATH_IDENTITY  = 2'd1;
    localparam logic [1:0] PATH_FALLBACK  = 2'd2;
    localparam logic [1:0] PATH_GENERATED = 2'd3;

    typedef logic signed [QV_W-1:0] qv_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } axis_t;

    typedef struct packed {
        logic        ident;
        logic [1:0]  path;
        logic [63:0] p;
        qv_t         dot;
        qv_t         qx;
        qv_t         qy;
        qv_t         qz;
    } q_item_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } isq_t;

    // One digit of the bitwise integer square root.
    function automatic isq_t isq_step(input logic [63:0] x, input logic [63:0] r,
                                      input logic [63:0] bitv);
        isq_t        s;
        logic [63:0] t;
        t = r + bitv;
        if (x >= t)
        begin
            s.x = x - t;
            s.r = (r >> 1) + bitv;
        end
        else
        begin
            s.x = x;
            s.r = r >> 1;
        end
        return s;
    endfunction

endpackage

// File: rtl/saq_isqrt.sv
module saq_isqrt
    import saq_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x,
    output logic [31:0] root
);

    logic [63:0] x_reg [ISQ_STEPS];
    logic [63:0] r_reg [ISQ_STEPS];

    // One root bit per stage, most significant first.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {x_reg[0], r_reg[0]} <= isq_step(x, 64'd0, 64'd1 << ISQ_TOP);
            for (int i = 1; i < ISQ_STEPS; i++)
            begin
                {x_reg[i], r_reg[i]} <= isq_step(x_reg[i-1], r_reg[i-1],
                                                 64'd1 << (ISQ_TOP - 2 * i));
            end
        end
    end

    assign root = r_reg[ISQ_STEPS-1][31:0];

endmodule

// File: rtl/saq_queue.sv
module saq_queue
    import saq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  q_item_t                      push_item,
    input  logic                         pop,
    output q_item_t                      rd_item,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         empty
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t          mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_item <= mem[rd_ptr_reg];
        end
    end

    assign count = count_reg;
    assign empty = (count_reg == '0);

endmodule

// File: rtl/saq_front.sv
module saq_front
    import saq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 src_x,
    input  logic signed [15:0]                 src_y,
    input  logic signed [15:0]                 src_z,
    input  logic signed [15:0]                 dst_x,
    input  logic signed [15:0]                 dst_y,
    input  logic signed [15:0]                 dst_z,
    input  axis_t                              fallback,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
    output logic                               push,
    output q_item_t                            push_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [31:0] mag_c(input qv_t v);
        qv_t a;
        a = (v < 0) ? -v : v;
        return a[31:0];
    endfunction

    logic acc;
    logic v1_reg, v2_reg, v3_reg;
    logic [CNT_W:0] committed;

    // Stage 1: products
    logic signed [15:0] sx1_reg, sy1_reg, sz1_reg;
    logic signed [31:0] sxx_reg, syy_reg, szz_reg, txx_reg, tyy_reg, tzz_reg;
    logic signed [31:0] dx_reg, dy_reg, dz_reg;
    logic signed [31:0] yz_reg, zy_reg, zx_reg, xz_reg, xy_reg, yx_reg;

    // Stage 2: sums
    logic signed [15:0] sx2_reg, sy2_reg, sz2_reg;
    logic [31:0]        s2_reg, t2_reg;
    qv_t                dot2_reg, cx2_reg, cy2_reg, cz2_reg;

    // Stage 3: wide products
    logic signed [15:0] sx3_reg, sy3_reg, sz3_reg;
    logic               zero3_reg;
    logic [63:0]        p3_reg, c2x_reg, c2y_reg, c2z_reg;
    qv_t                dot3_reg, cx3_reg, cy3_reg, cz3_reg;

    logic [63:0] c2;
    logic        opposite;

    // Every item in flight already owns a queue slot, so the queue never overflows.
    assign committed = (CNT_W+1)'(q_count) + (CNT_W+1)'(v1_reg)
                     + (CNT_W+1)'(v2_reg) + (CNT_W+1)'(v3_reg);
    assign in_stall  = (committed >= (CNT_W+1)'(QUEUE_DEPTH));
    assign acc       = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx1_reg <= src_x;
        sy1_reg <= src_y;
        sz1_reg <= src_z;
        sxx_reg <= 32'(src_x) * 32'(src_x);
        syy_reg <= 32'(src_y) * 32'(src_y);
        szz_reg <= 32'(src_z) * 32'(src_z);
        txx_reg <= 32'(dst_x) * 32'(dst_x);
        tyy_reg <= 32'(dst_y) * 32'(dst_y);
        tzz_reg <= 32'(dst_z) * 32'(dst_z);
        dx_reg  <= 32'(src_x) * 32'(dst_x);
        dy_reg  <= 32'(src_y) * 32'(dst_y);
        dz_reg  <= 32'(src_z) * 32'(dst_z);
        yz_reg  <= 32'(src_y) * 32'(dst_z);
        zy_reg  <= 32'(src_z) * 32'(dst_y);
        zx_reg  <= 32'(src_z) * 32'(dst_x);
        xz_reg  <= 32'(src_x) * 32'(dst_z);
        xy_reg  <= 32'(src_x) * 32'(dst_y);
        yx_reg  <= 32'(src_y) * 32'(dst_x);

        sx2_reg  <= sx1_reg;
        sy2_reg  <= sy1_reg;
        sz2_reg  <= sz1_reg;
        s2_reg   <= $unsigned(sxx_reg) + $unsigned(syy_reg) + $unsigned(szz_reg);
        t2_reg   <= $unsigned(txx_reg) + $unsigned(tyy_reg) + $unsigned(tzz_reg);
        dot2_reg <= qv_t'(dx_reg) + qv_t'(dy_reg) + qv_t'(dz_reg);
        cx2_reg  <= qv_t'(yz_reg) - qv_t'(zy_reg);
        cy2_reg  <= qv_t'(zx_reg) - qv_t'(xz_reg);
        cz2_reg  <= qv_t'(xy_reg) - qv_t'(yx_reg);

        sx3_reg   <= sx2_reg;
        sy3_reg   <= sy2_reg;
        sz3_reg   <= sz2_reg;
        zero3_reg <= (s2_reg == '0) || (t2_reg == '0);
        p3_reg    <= 64'(s2_reg) * 64'(t2_reg);
        c2x_reg   <= 64'(mag_c(cx2_reg)) * 64'(mag_c(cx2_reg));
        c2y_reg   <= 64'(mag_c(cy2_reg)) * 64'(mag_c(cy2_reg));
        c2z_reg   <= 64'(mag_c(cz2_reg)) * 64'(mag_c(cz2_reg));
        dot3_reg  <= dot2_reg;
        cx3_reg   <= cx2_reg;
        cy3_reg   <= cy2_reg;
        cz3_reg   <= cz2_reg;
    end

    // Nearly opposite when the dot is negative and sin^2 of the angle is below 2^-19.
    assign c2       = c2x_reg + c2y_reg + c2z_reg;
    assign opposite = (dot3_reg < 0) && (c2 < (64'd1 << 45)) && ((c2 << 19) < p3_reg);

    always_comb
    begin
        push_item.ident = 1'b0;
        push_item.path  = PATH_GENERAL;
        push_item.p     = p3_reg;
        push_item.dot   = dot3_reg;
        push_item.qx    = cx3_reg;
        push_item.qy    = cy3_reg;
        push_item.qz    = cz3_reg;
        if (zero3_reg || ((c2 == '0) && (dot3_reg > 0)))
        begin
            push_item.ident = 1'b1;
            push_item.path  = PATH_IDENTITY;
        end
        else if (opposite)
        begin
            // A zero root and a zero dot leave the scalar part at zero.
            push_item.p   = '0;
            push_item.dot = '0;
            if (fallback != '0)
            begin
                push_item.path = PATH_FALLBACK;
                push_item.qx   = qv_t'(fallback.x);
                push_item.qy   = qv_t'(fallback.y);
                push_item.qz   = qv_t'(fallback.z);
            end
            else if ((sy3_reg != '0) || (sz3_reg != '0))
            begin
                push_item.path = PATH_GENERATED;
                push_item.qx   = '0;
                push_item.qy   = -qv_t'(sz3_reg);
                push_item.qz   = qv_t'(sy3_reg);
            end
            else
            begin
                push_item.path = PATH_GENERATED;
                push_item.qx   = '0;
                push_item.qy   = '0;
                push_item.qz   = -qv_t'(sx3_reg);
            end
        end
    end

    assign push = v3_reg;

endmodule

// File: rtl/saq_back.sv
module saq_back
    import saq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  q_item_t            q_item,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [1:0]         path_taken
);

    typedef struct packed {
        logic       ident;
        logic [1:0] path;
        qv_t        dot;
        qv_t        qx;
        qv_t        qy;
        qv_t        qz;
    } side1_t;

    typedef struct packed {
        logic       ident;
        logic [1:0] path;
        logic [3:0] neg;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [3:0][29:0] a;
    } side2_t;

    function automatic logic [33:0] mag_q(input qv_t v);
        qv_t m;
        m = (v < 0) ? -v : v;
        return m[33:0];
    endfunction

    function automatic logic [47:0] div_step(input logic [46:0] rem, input logic [46:0] trial);
        if (rem >= trial)
        begin
            return {1'b1, rem - trial};
        end
        return {1'b0, rem};
    endfunction

    logic en;
    logic b0_valid_reg;

    logic [ISQ_STEPS-1:0] s1v_reg;
    side1_t               s1_reg [ISQ_STEPS];
    logic [31:0]          root1, root2;
    qv_t                  qn [4];

    logic        n1_valid_reg, n2_valid_reg, n3_valid_reg, n4_valid_reg, n5_valid_reg;
    tag_t        n1_tag_reg, n2_tag_reg, n3_tag_reg, n4_tag_reg;
    logic [33:0] n1_m_reg [4];
    logic [33:0] n2_m_reg [4];
    logic [33:0] n2_mx_reg;
    logic [33:0] mx_ab, mx_cd;
    logic [29:0] n3_a_reg [4];
    logic [29:0] n4_a_reg [4];
    logic [59:0] n4_sq_reg [4];
    side2_t      n5_reg;
    logic [61:0] n5_n2_reg;

    logic [ISQ_STEPS-1:0] s2v_reg;
    side2_t               s2_reg [ISQ_STEPS];
    logic [30:0]          nn;

    logic        d0_valid_reg;
    tag_t        d0_tag_reg;
    logic [46:0] d0_num_reg [4];
    logic [31:0] d0_dv_reg;

    logic [DIV_STEPS-1:0] dv_v_reg;
    tag_t                 dv_tag_reg [DIV_STEPS];
    logic [31:0]          dv_d_reg [DIV_STEPS];
    logic [46:0]          dv_rem_reg [DIV_STEPS][4];
    logic [14:0]          dv_quo_reg [DIV_STEPS][4];
    logic [47:0]          ds [DIV_STEPS][4];

    logic [15:0] lane_out [4];

    // The whole back end moves together and freezes while a result is held.
    assign en  = !(out_valid && out_stall);
    assign pop = en && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            s1v_reg      <= '0;
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            n3_valid_reg <= 1'b0;
            n4_valid_reg <= 1'b0;
            n5_valid_reg <= 1'b0;
            s2v_reg      <= '0;
            d0_valid_reg <= 1'b0;
            dv_v_reg     <= '0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg <= !q_empty;
            s1v_reg      <= {s1v_reg[ISQ_STEPS-2:0], b0_valid_reg};
            n1_valid_reg <= s1v_reg[ISQ_STEPS-1];
            n2_valid_reg <= n1_valid_reg;
            n3_valid_reg <= n2_valid_reg;
            n4_valid_reg <= n3_valid_reg;
            n5_valid_reg <= n4_valid_reg;
            s2v_reg      <= {s2v_reg[ISQ_STEPS-2:0], n5_valid_reg};
            d0_valid_reg <= s2v_reg[ISQ_STEPS-1];
            dv_v_reg     <= {dv_v_reg[DIV_STEPS-2:0], d0_valid_reg};
            out_valid    <= dv_v_reg[DIV_STEPS-1];
        end
    end

    saq_isqrt u_isqrt_p
    (
        .clk  (clk),
        .en   (en),
        .x    (q_item.p),
        .root (root1)
    );

    saq_isqrt u_isqrt_n
    (
        .clk  (clk),
        .en   (en),
        .x    (64'(n5_n2_reg)),
        .root (root2)
    );

    assign qn[0] = qv_t'(root1) + s1_reg[ISQ_STEPS-1].dot;
    assign qn[1] = s1_reg[ISQ_STEPS-1].qx;
    assign qn[2] = s1_reg[ISQ_STEPS-1].qy;
    assign qn[3] = s1_reg[ISQ_STEPS-1].qz;

    assign mx_ab = (n1_m_reg[0] > n1_m_reg[1]) ? n1_m_reg[0] : n1_m_reg[1];
    assign mx_cd = (n1_m_reg[2] > n1_m_reg[3]) ? n1_m_reg[2] : n1_m_reg[3];
    assign nn    = root2[30:0];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            ds[0][l] = div_step(d0_num_reg[l], 47'(d0_dv_reg) << (DIV_STEPS - 1));
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                ds[j][l] = div_step(dv_rem_reg[j-1][l],
                                    47'(dv_d_reg[j-1]) << (DIV_STEPS - 1 - j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg[0] <= '{ident: q_item.ident, path: q_item.path, dot: q_item.dot,
                           qx: q_item.qx, qy: q_item.qy, qz: q_item.qz};
            for (int i = 1; i < ISQ_STEPS; i++)
            begin
                s1_reg[i] <= s1_reg[i-1];
            end

            n1_tag_reg.ident <= s1_reg[ISQ_STEPS-1].ident;
            n1_tag_reg.path  <= s1_reg[ISQ_STEPS-1].path;
            for (int l = 0; l < 4; l++)
            begin
                n1_m_reg[l]          <= mag_q(qn[l]);
                n1_tag_reg.neg[l]    <= (qn[l] < 0);
            end

            n2_tag_reg <= n1_tag_reg;
            n2_m_reg   <= n1_m_reg;
            n2_mx_reg  <= (mx_ab > mx_cd) ? mx_ab : mx_cd;

            // Drop low bits until the largest magnitude fits in 30 bits.
            n3_tag_reg <= n2_tag_reg;
            for (int l = 0; l < 4; l++)
            begin
                if (n2_mx_reg < (34'd1 << 30))
                begin
                    n3_a_reg[l] <= n2_m_reg[l][29:0];
                end
                else if (n2_mx_reg < (34'd1 << 31))
                begin
                    n3_a_reg[l] <= n2_m_reg[l][30:1];
                end
                else if (n2_mx_reg < (34'd1 << 32))
                begin
                    n3_a_reg[l] <= n2_m_reg[l][31:2];
                end
                else if (n2_mx_reg < (34'd1 << 33))
                begin
                    n3_a_reg[l] <= n2_m_reg[l][32:3];
                end
                else
                begin
                    n3_a_reg[l] <= n2_m_reg[l][33:4];
                end
            end

            n4_tag_reg <= n3_tag_reg;
            n4_a_reg   <= n3_a_reg;
            for (int l = 0; l < 4; l++)
            begin
                n4_sq_reg[l] <= 60'(n3_a_reg[l]) * 60'(n3_a_reg[l]);
            end

            n5_reg.tag <= n4_tag_reg;
            for (int l = 0; l < 4; l++)
            begin
                n5_reg.a[l] <= n4_a_reg[l];
            end
            n5_n2_reg <= 62'(n4_sq_reg[0]) + 62'(n4_sq_reg[1])
                       + 62'(n4_sq_reg[2]) + 62'(n4_sq_reg[3]);

            s2_reg[0] <= n5_reg;
            for (int i = 1; i < ISQ_STEPS; i++)
            begin
                s2_reg[i] <= s2_reg[i-1];
            end

            // Rounded quotient a * 2^14 / N, worked as (a * 2^15 + N) / 2N.
            d0_tag_reg <= '{ident: s2_reg[ISQ_STEPS-1].tag.ident || (nn == '0),
                            path:  s2_reg[ISQ_STEPS-1].tag.path,
                            neg:   s2_reg[ISQ_STEPS-1].tag.neg};
            d0_dv_reg  <= {nn, 1'b0};
            for (int l = 0; l < 4; l++)
            begin
                d0_num_reg[l] <= (47'(s2_reg[ISQ_STEPS-1].a[l]) << 15) + 47'(nn);
            end

            dv_tag_reg[0] <= d0_tag_reg;
            dv_d_reg[0]   <= d0_dv_reg;
            for (int l = 0; l < 4; l++)
            begin
                dv_rem_reg[0][l] <= ds[0][l][46:0];
                dv_quo_reg[0][l] <= {14'd0, ds[0][l][47]};
            end
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                dv_tag_reg[j] <= dv_tag_reg[j-1];
                dv_d_reg[j]   <= dv_d_reg[j-1];
                for (int l = 0; l < 4; l++)
                begin
                    dv_rem_reg[j][l] <= ds[j][l][46:0];
                    dv_quo_reg[j][l] <= {dv_quo_reg[j-1][l][13:0], ds[j][l][47]};
                end
            end

            quat_w     <= lane_out[0];
            quat_x     <= lane_out[1];
            quat_y     <= lane_out[2];
            quat_z     <= lane_out[3];
            path_taken <= dv_tag_reg[DIV_STEPS-1].path;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (dv_tag_reg[DIV_STEPS-1].neg[l])
            begin
                lane_out[l] = -{1'b0, dv_quo_reg[DIV_STEPS-1][l]};
            end
            else
            begin
                lane_out[l] = {1'b0, dv_quo_reg[DIV_STEPS-1][l]};
            end
        end
        if (dv_tag_reg[DIV_STEPS-1].ident)
        begin
            lane_out[0] = ONE_Q14;
            lane_out[1] = '0;
            lane_out[2] = '0;
            lane_out[3] = '0;
        end
    end

endmodule

// File: rtl/shortest_arc_quaternion_top.sv
// Channel   Direction  Handshake              Beat contents
// input     in         in_valid / in_stall    src_x..src_z, dst_x..dst_z
// output    out        out_valid / out_stall  quat_w..quat_z, path_taken
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is taken per cycle while in_stall is low; each result passes through the two
// 32-stage square-root pipelines and the 15-stage divider.
// Each beat reserves a queue slot when taken; the input stalls once the queued beats
// and the beats still in the three front stages fill every slot.
// A stalled result freezes the back end while the front end keeps filling the queue.
// Reset clears the fallback axis to zero and empties every pipeline; cfg_ready is always high.
module shortest_arc_quaternion_top
    import saq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] src_x,
    input  logic signed [15:0] src_y,
    input  logic signed [15:0] src_z,
    input  logic signed [15:0] dst_x,
    input  logic signed [15:0] dst_y,
    input  logic signed [15:0] dst_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [1:0]         path_taken,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_FALLBACK_X = 2'd0;
    localparam logic [1:0] REG_FALLBACK_Y = 2'd1;
    localparam logic [1:0] REG_FALLBACK_Z = 2'd2;

    axis_t            fallback_reg;
    logic             push, pop, q_empty;
    q_item_t          push_item, rd_item;
    logic [CNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FALLBACK_X: fallback_reg.x <= cfg_data;
                REG_FALLBACK_Y: fallback_reg.y <= cfg_data;
                REG_FALLBACK_Z: fallback_reg.z <= cfg_data;
                default:        fallback_reg   <= fallback_reg;
            endcase
        end
    end

    saq_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_z     (src_z),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .dst_z     (dst_z),
        .fallback  (fallback_reg),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    saq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .rd_item   (rd_item),
        .count     (q_count),
        .empty     (q_empty)
    );

    saq_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (rd_item),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .path_taken (path_taken)
    );

endmodule

// File: test/tb_shortest_arc_quaternion_top.sv
`timescale 1ns / 100ps

module tb_shortest_arc_quaternion_top;
    import saq_pkg::*;

    localparam logic [1:0] REG_FB_X = 2'd0;
    localparam logic [1:0] REG_FB_Y = 2'd1;
    localparam logic [1:0] REG_FB_Z = 2'd2;
    localparam int         IDLE_LIMIT = 20000;
    localparam int         DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [1:0]         path;
    } quat_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0]         path_taken;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    axis_t     fb_axis;
    quat_res_t expected_quats[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        quiet_tail;

    shortest_arc_quaternion_top dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic quat_res_t unit_quat(input longint q[4], input logic [1:0] path);
        logic [63:0] m[4];
        logic [63:0] mx, n2, nn, v;
        logic [15:0] o[4];
        int          k;
        quat_res_t   r;
        mx = 0;
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = (q[i] < 0) ? -q[i] : q[i];
            if (m[i] > mx)
                mx = m[i];
        end
        k = 0;
        while ((mx >> k) >= (64'd1 << 30))
            k++;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = m[i] >> k;
            n2 += m[i] * m[i];
        end
        nn = int_sqrt(n2);
        if (nn == 0)
        begin
            r = '{ONE_Q14, 16'sd0, 16'sd0, 16'sd0, path};
            return r;
        end
        for (int i = 0; i < 4; i++)
        begin
            v = ((m[i] << 15) + nn) / (2 * nn);
            if (q[i] < 0)
                v = -v;
            o[i] = v[15:0];
        end
        r = '{o[0], o[1], o[2], o[3], path};
        return r;
    endfunction

    function automatic quat_res_t predict_arc(input longint sx, sy, sz, tx, ty, tz);
        longint      dot, cx, cy, cz;
        logic [63:0] s2, t2, p, c2;
        longint      q[4];
        quat_res_t   idn;
        idn = '{ONE_Q14, 16'sd0, 16'sd0, 16'sd0, PATH_IDENTITY};
        s2 = sx * sx + sy * sy + sz * sz;
        t2 = tx * tx + ty * ty + tz * tz;
        if (s2 == 0 || t2 == 0)
            return idn;
        dot = sx * tx + sy * ty + sz * tz;
        cx = sy * tz - sz * ty;
        cy = sz * tx - sx * tz;
        cz = sx * ty - sy * tx;
        p = s2 * t2;
        c2 = cx * cx + cy * cy + cz * cz;
        if (c2 == 0 && dot > 0)
            return idn;
        if (dot < 0 && c2 < (64'd1 << 45) && (c2 << 19) < p)
        begin
            q[0] = 0;
            if (fb_axis != '0)
            begin
                q[1] = fb_axis.x;
                q[2] = fb_axis.y;
                q[3] = fb_axis.z;
                return unit_quat(q, PATH_FALLBACK);
            end
            q[1] = 0;
            q[2] = -sz;
            q[3] = sy;
            if (sy == 0 && sz == 0)
            begin
                q[1] = sz;
                q[2] = 0;
                q[3] = -sx;
            end
            return unit_quat(q, PATH_GENERATED);
        end
        q[0] = longint'(int_sqrt(p)) + dot;
        q[1] = cx;
        q[2] = cy;
        q[3] = cz;
        return unit_quat(q, PATH_GENERAL);
    endfunction

    task automatic random_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // The valid stays high into the next beat unless a gap or a drain drops it.
    task automatic send_pair(input logic signed [15:0] sx, sy, sz, tx, ty, tz);
        random_gap();
        in_valid <= 1'b1;
        src_x <= sx;
        src_y <= sy;
        src_z <= sz;
        dst_x <= tx;
        dst_y <= ty;
        dst_z <= tz;
        expected_quats.push_back(predict_arc(sx, sy, sz, tx, ty, tz));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FB_X: fb_axis.x = val;
            REG_FB_Y: fb_axis.y = val;
            REG_FB_Z: fb_axis.z = val;
            default: ;
        endcase
    endtask

    task automatic set_axis(input logic [15:0] ax, ay, az);
        wait_drained();
        write_reg(REG_FB_X, ax);
        write_reg(REG_FB_Y, ay);
        write_reg(REG_FB_Z, az);
        cfg_valid <= 1'b0;
    endtask

    // A destination pointing against the source, either negated or negated at half length.
    task automatic send_opposite();
        logic signed [15:0] sx, sy, sz;
        int                 sc;
        sx = 16'($urandom);
        sy = 16'($urandom);
        sz = 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin sy = 0; sz = 0; end
            1: sz = 0;
            default: ;
        endcase
        sc = $urandom_range(0, 1) ? 1 : 0;
        if (sc == 1)
            send_pair(sx, sy, sz, -(sx >>> 1), -(sy >>> 1), -(sz >>> 1));
        else
            send_pair(sx, sy, sz, -sx, -sy, -sz);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 100, 200, 300);
        send_pair(5, 6, 7, 0, 0, 0);
        send_pair(100, 0, 0, 200, 0, 0);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, -32768, -32768, -32768);
        send_pair(-32768, 0, 0, 32767, 0, 0);
        send_pair(1, 0, 0, -1, 0, 0);
        send_pair(0, 1, 0, 0, -1, 0);
        send_pair(0, 0, -32768, 0, 0, 32767);
        send_pair(1, 0, 0, 0, 1, 0);
        send_pair(32767, 0, 0, 0, 0, 32767);
        send_pair(32767, -32768, 1, -1, 32767, -32768);
        send_pair(30000, 1, 0, -30000, 0, 0);
        send_pair(1000, 2000, -3000, -1000, -2000, 3000);
        send_pair(-1, -1, -1, 1, 1, 1);
        send_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_fallback();
        set_axis(16'h7FFF, 16'h0000, 16'h0000);
        send_pair(1, 0, 0, -1, 0, 0);
        send_pair(-32768, 5, 0, 32767, -5, 0);
        set_axis(16'h8000, 16'h8000, 16'h8000);
        send_pair(0, 32767, 0, 0, -32768, 0);
        send_pair(1000, 2000, -3000, -1000, -2000, 3000);
        set_axis(16'h0000, 16'h0000, 16'h0001);
        send_pair(7, 7, 7, -7, -7, -7);
        send_pair(3, 4, 0, 4, -3, 0);
    endtask

    task automatic test_random(input int n);
        logic signed [15:0] v[6];
        for (int i = 0; i < n; i++)
        begin
            if (i % 150 == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    set_axis(0, 0, 0);
                else
                    set_axis(16'($urandom), 16'($urandom), 16'($urandom));
            end
            case ($urandom_range(0, 9))
                0, 1, 2: send_opposite();
                3:
                begin
                    v[0] = 16'($urandom);
                    v[1] = 16'($urandom);
                    v[2] = 16'($urandom);
                    send_pair(v[0], v[1], v[2], v[0] >>> $urandom_range(0, 4),
                              v[1] >>> 0, v[2]);
                end
                4:
                begin
                    for (int j = 0; j < 6; j++)
                        v[j] = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                    send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
                end
                default:
                begin
                    for (int j = 0; j < 6; j++)
                        v[j] = 16'($urandom);
                    send_pair(v[0], v[1], v[2], v[3], v[4], v[5]);
                end
            endcase
        end
    endtask

    // Output stalls come in random bursts; the quiet tail turns them off.
    always @(posedge clk)
    begin
        if (quiet_tail)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        quat_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                e = expected_quats.pop_front();
                if (quat_w !== e.w)
                begin
                    $error("quat_w expected %0d actual %0d", e.w, quat_w);
                    error_count++;
                end
                if (quat_x !== e.x)
                begin
                    $error("quat_x expected %0d actual %0d", e.x, quat_x);
                    error_count++;
                end
                if (quat_y !== e.y)
                begin
                    $error("quat_y expected %0d actual %0d", e.y, quat_y);
                    error_count++;
                end
                if (quat_z !== e.z)
                begin
                    $error("quat_z expected %0d actual %0d", e.z, quat_z);
                    error_count++;
                end
                if (path_taken !== e.path)
                begin
                    $error("path_taken expected %0d actual %0d", e.path, path_taken);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_shortest_arc_quaternion_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FB_X;
        cfg_data = '0;
        {src_x, src_y, src_z, dst_x, dst_y, dst_z} = '0;
        fb_axis = '0;
        quiet_tail = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fallback();
        set_axis(0, 0, 0);
        test_random(700);
        quiet_tail = 1'b1;
        test_random(130);
        wait_drained();
        if (error_count == 0)
            $display("tb_shortest_arc_quaternion_top: done, clean");
        else
            $display("tb_shortest_arc_quaternion_top: done, errors");
        $finish;
    end

endmodule
